/* rtl/ple_pkg.sv */
// Shared types and constants for the positional list engine.
package ple_pkg;

    localparam int OPCODE_W   = 3;
    localparam int POSITION_W = 7;
    localparam int VALUE_W    = 32;
    localparam int STATUS_W   = 3;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 40;

    typedef enum logic [OPCODE_W-1:0] {
        OP_CREATE    = 3'd0,
        OP_INS_FRONT = 3'd1,
        OP_INS_END   = 3'd2,
        OP_INS_AT    = 3'd3,
        OP_DEL_FIRST = 3'd4,
        OP_DEL_LAST  = 3'd5,
        OP_DEL_AT    = 3'd6,
        OP_DISPLAY   = 3'd7
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 3'd0,
        ST_EXISTS = 3'd1,
        ST_EMPTY  = 3'd2,
        ST_BADPOS = 3'd3,
        ST_FULL   = 3'd4
    } status_t;

    // One result transaction handed from the sequencer to the output register.
    typedef struct packed {
        logic                      valid;
        status_t                   status;
        logic signed [VALUE_W-1:0] value;
        logic [POSITION_W-1:0]     position;
        logic                      last;
    } res_t;

endpackage

/* rtl/ple_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
module ple_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (re)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/ple_ctrl.sv */
// Sequencer that decodes a list operation and walks the entry RAM one slot a cycle when shifting entries.
module ple_ctrl #(
    parameter int CAPACITY = 64
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  ple_pkg::opcode_t                     in_opcode,
    input  logic [ple_pkg::POSITION_W-1:0]       in_position,
    input  logic signed [ple_pkg::VALUE_W-1:0]   in_value,
    output logic                                 ram_we,
    output logic [$clog2(CAPACITY)-1:0]          ram_wr_addr,
    output logic [ple_pkg::VALUE_W-1:0]          ram_wr_data,
    output logic                                 ram_re,
    output logic [$clog2(CAPACITY)-1:0]          ram_rd_addr,
    input  logic [ple_pkg::VALUE_W-1:0]          ram_rd_data,
    output ple_pkg::res_t                        res,
    input  logic                                 res_ready
);
    import ple_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int LW = $clog2(CAPACITY + 1);
    localparam int CW = ((LW > POSITION_W) ? LW : POSITION_W) + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SHIFT_UP,
        S_INS_WR,
        S_DEL_RD,
        S_SHIFT_DN,
        S_DISP_WAIT,
        S_EMIT
    } state_t;

    state_t                    state_reg, state_next;
    logic [LW-1:0]             len_reg, len_next;
    logic                      res_valid_reg, res_valid_next;
    opcode_t                   op_reg, op_next;
    logic [POSITION_W-1:0]     pos_reg, pos_next;
    logic signed [VALUE_W-1:0] val_reg, val_next;
    logic [AW-1:0]             tgt_reg, tgt_next;
    logic [AW-1:0]             addr_reg, addr_next;
    res_t                      res_reg, res_next;

    logic [CW-1:0] len_ext, len_inc, len_dec, pos_ext, pos_dec, addr_pos;
    logic [AW-1:0] last_idx, addr_inc, addr_dec, tgt_w;
    logic          is_empty, is_full, bad_ins, bad_del;

    // The index incrementer and decrementer compute the walk addresses.
    assign len_ext  = CW'(len_reg);
    assign len_inc  = len_ext + CW'(1);
    assign len_dec  = len_ext - CW'(1);
    assign pos_ext  = CW'(pos_reg);
    assign pos_dec  = pos_ext - CW'(1);
    assign addr_pos = CW'(addr_reg) + CW'(1);
    assign last_idx = len_dec[AW-1:0];
    assign addr_inc = addr_reg + AW'(1);
    assign addr_dec = addr_reg - AW'(1);
    assign is_empty = (len_reg == '0);
    assign is_full  = (len_reg == LW'(CAPACITY));
    assign bad_ins  = (pos_reg == '0) || (pos_ext > len_inc);
    assign bad_del  = (pos_reg == '0) || (pos_ext > len_ext);

    always_comb
    begin
        state_next     = state_reg;
        len_next       = len_reg;
        res_valid_next = res_valid_reg;
        op_next        = op_reg;
        pos_next       = pos_reg;
        val_next       = val_reg;
        tgt_next       = tgt_reg;
        addr_next      = addr_reg;
        res_next       = res_reg;
        ram_we         = 1'b0;
        ram_wr_addr    = addr_inc;
        ram_wr_data    = ram_rd_data;
        ram_re         = 1'b0;
        ram_rd_addr    = addr_dec;
        tgt_w          = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = in_opcode;
                    pos_next   = in_position;
                    val_next   = in_value;
                    state_next = S_DECODE;
                end
            end

            S_DECODE:
            begin
                // Errors and the simple success results go straight to the emit state.
                res_next.status   = ST_OK;
                res_next.value    = val_reg;
                res_next.position = 7'd1;
                res_next.last     = 1'b1;
                case (op_reg)
                    OP_CREATE:
                    begin
                        if (!is_empty)
                        begin
                            res_next.status = ST_EXISTS;
                        end
                        else
                        begin
                            ram_we      = 1'b1;
                            ram_wr_addr = '0;
                            ram_wr_data = val_reg;
                            len_next    = LW'(1);
                        end
                        state_next = S_EMIT;
                    end

                    OP_INS_FRONT, OP_INS_END, OP_INS_AT:
                    begin
                        if (op_reg == OP_INS_AT && bad_ins)
                        begin
                            res_next.status = ST_BADPOS;
                            state_next      = S_EMIT;
                        end
                        else if (is_full)
                        begin
                            res_next.status = ST_FULL;
                            state_next      = S_EMIT;
                        end
                        else
                        begin
                            if (op_reg == OP_INS_FRONT)
                            begin
                                tgt_w = '0;
                            end
                            else if (op_reg == OP_INS_END)
                            begin
                                tgt_w             = len_ext[AW-1:0];
                                res_next.position = len_inc[POSITION_W-1:0];
                            end
                            else
                            begin
                                tgt_w             = pos_dec[AW-1:0];
                                res_next.position = pos_reg;
                            end
                            tgt_next = tgt_w;
                            if (CW'(tgt_w) == len_ext)
                            begin
                                state_next = S_INS_WR;
                            end
                            else
                            begin
                                ram_re      = 1'b1;
                                ram_rd_addr = last_idx;
                                addr_next   = last_idx;
                                state_next  = S_SHIFT_UP;
                            end
                        end
                    end

                    OP_DEL_FIRST, OP_DEL_LAST, OP_DEL_AT:
                    begin
                        if (is_empty)
                        begin
                            res_next.status = ST_EMPTY;
                            state_next      = S_EMIT;
                        end
                        else if (op_reg == OP_DEL_AT && bad_del)
                        begin
                            res_next.status = ST_BADPOS;
                            state_next      = S_EMIT;
                        end
                        else
                        begin
                            if (op_reg == OP_DEL_FIRST)
                            begin
                                tgt_w = '0;
                            end
                            else if (op_reg == OP_DEL_LAST)
                            begin
                                tgt_w             = last_idx;
                                res_next.position = len_ext[POSITION_W-1:0];
                            end
                            else
                            begin
                                tgt_w             = pos_dec[AW-1:0];
                                res_next.position = pos_reg;
                            end
                            tgt_next    = tgt_w;
                            ram_re      = 1'b1;
                            ram_rd_addr = tgt_w;
                            addr_next   = tgt_w;
                            state_next  = S_DEL_RD;
                        end
                    end

                    OP_DISPLAY:
                    begin
                        if (is_empty)
                        begin
                            res_next.status = ST_EMPTY;
                            state_next      = S_EMIT;
                        end
                        else
                        begin
                            ram_re      = 1'b1;
                            ram_rd_addr = '0;
                            addr_next   = '0;
                            state_next  = S_DISP_WAIT;
                        end
                    end

                    default:
                    begin
                        state_next = S_EMIT;
                    end
                endcase
                if (res_next.status != ST_OK)
                begin
                    res_next.value    = '0;
                    res_next.position = '0;
                end
                if (state_next == S_EMIT)
                begin
                    res_valid_next = 1'b1;
                end
            end

            S_SHIFT_UP:
            begin
                // Move the entry read last cycle up one slot, then read the one below.
                ram_we      = 1'b1;
                ram_wr_addr = addr_inc;
                ram_wr_data = ram_rd_data;
                if (addr_reg == tgt_reg)
                begin
                    state_next = S_INS_WR;
                end
                else
                begin
                    ram_re      = 1'b1;
                    ram_rd_addr = addr_dec;
                    addr_next   = addr_dec;
                end
            end

            S_INS_WR:
            begin
                ram_we         = 1'b1;
                ram_wr_addr    = tgt_reg;
                ram_wr_data    = val_reg;
                len_next       = len_inc[LW-1:0];
                res_valid_next = 1'b1;
                state_next     = S_EMIT;
            end

            S_DEL_RD:
            begin
                res_next.value = signed'(ram_rd_data);
                if (addr_reg == last_idx)
                begin
                    len_next       = len_dec[LW-1:0];
                    res_valid_next = 1'b1;
                    state_next     = S_EMIT;
                end
                else
                begin
                    ram_re      = 1'b1;
                    ram_rd_addr = addr_inc;
                    addr_next   = addr_inc;
                    state_next  = S_SHIFT_DN;
                end
            end

            S_SHIFT_DN:
            begin
                // Move the entry read last cycle down one slot, then read the next one.
                ram_we      = 1'b1;
                ram_wr_addr = addr_dec;
                ram_wr_data = ram_rd_data;
                if (addr_reg == last_idx)
                begin
                    len_next       = len_dec[LW-1:0];
                    res_valid_next = 1'b1;
                    state_next     = S_EMIT;
                end
                else
                begin
                    ram_re      = 1'b1;
                    ram_rd_addr = addr_inc;
                    addr_next   = addr_inc;
                end
            end

            S_DISP_WAIT:
            begin
                res_next.status   = ST_OK;
                res_next.value    = signed'(ram_rd_data);
                res_next.position = addr_pos[POSITION_W-1:0];
                res_next.last     = (addr_reg == last_idx);
                res_valid_next    = 1'b1;
                state_next        = S_EMIT;
            end

            S_EMIT:
            begin
                if (res_ready)
                begin
                    res_valid_next = 1'b0;
                    if (res_reg.last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ram_re      = 1'b1;
                        ram_rd_addr = addr_inc;
                        addr_next   = addr_inc;
                        state_next  = S_DISP_WAIT;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            len_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        pos_reg  <= pos_next;
        val_reg  <= val_next;
        tgt_reg  <= tgt_next;
        addr_reg <= addr_next;
        res_reg  <= res_next;
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        res       = res_reg;
        res.valid = res_valid_reg;
    end

    // The list never grows past its capacity.
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LW'(CAPACITY))
        else $error("list length beyond capacity");

    // Writes land inside the list or on the slot just past its end.
    a_wr_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (LW'(ram_wr_addr) <= len_reg))
        else $error("RAM write beyond the end of the list");

    // Reads only touch live entries.
    a_rd_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        ram_re |-> (LW'(ram_rd_addr) < len_reg))
        else $error("RAM read of an entry outside the list");

    // A walk never reads and writes the same slot in one cycle.
    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && ram_re) |-> (ram_wr_addr != ram_rd_addr))
        else $error("RAM read and write collide");

    // No result is offered while a new transaction can be taken.
    a_res_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> !in_ready)
        else $error("result pending while the sequencer is idle");

endmodule

/* rtl/positional_list_engine_unit.sv */
// Top level of the positional list engine: stream ports, entry RAM, sequencer, output register.
//
// This block keeps an ordered list of up to CAPACITY signed 32-bit values in a
// single RAM, front entry at address 0, and applies one list operation per input
// transaction. Each input transaction carries an opcode in s_tuser and a 1-based
// position and a value in s_tdata. Every operation returns exactly one result
// transaction except display, which returns one result per entry in order with
// m_tlast set on the final one (an empty list returns a single error result).
// The block handles one operation at a time and drops s_tready until the
// operation's last result has been moved into the output register. Timing is
// set by the entry RAM, which has one write port and one registered read port,
// so a positional insert or delete moves one entry per cycle. The output
// register lets the next result be prepared while the current one waits. RAM
// entries are never read before they are written, so no clearing pass runs
// after reset.
module positional_list_engine_unit #(
    parameter int CAPACITY = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // s_tdata: [6:0] position, [38:7] value, [39] zero.
    input  logic [ple_pkg::S_TDATA_W-1:0]    s_tdata,
    // s_tuser: [2:0] opcode.
    input  logic [ple_pkg::OPCODE_W-1:0]     s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // m_tdata: [31:0] result_value, [38:32] result_position, [39] zero.
    output logic [ple_pkg::M_TDATA_W-1:0]    m_tdata,
    // m_tuser: [2:0] status.
    output logic [ple_pkg::STATUS_W-1:0]     m_tuser,
    // m_tlast: set on the final result of an input transaction.
    output logic                             m_tlast
);
    import ple_pkg::*;

    localparam int AW = $clog2(CAPACITY);

    logic                  ram_we;
    logic [AW-1:0]         ram_wr_addr;
    logic [VALUE_W-1:0]    ram_wr_data;
    logic                  ram_re;
    logic [AW-1:0]         ram_rd_addr;
    logic [VALUE_W-1:0]    ram_rd_data;
    res_t                  res;
    logic                  res_ready;

    logic                  m_tvalid_reg;
    status_t               status_reg;
    logic [VALUE_W-1:0]    value_reg;
    logic [POSITION_W-1:0] position_reg;
    logic                  last_reg;

    ple_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (CAPACITY)
    ) u_entries (
        .clk     (clk),
        .we      (ram_we),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .re      (ram_re),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    ple_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_opcode   (opcode_t'(s_tuser)),
        .in_position (s_tdata[POSITION_W-1:0]),
        .in_value    (signed'(s_tdata[POSITION_W+VALUE_W-1:POSITION_W])),
        .ram_we      (ram_we),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_re      (ram_re),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data),
        .res         (res),
        .res_ready   (res_ready)
    );

    // The output register takes a new result whenever it is empty or being drained.
    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            m_tvalid_reg <= res.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res.valid)
        begin
            status_reg   <= res.status;
            value_reg    <= res.value;
            position_reg <= res.position;
            last_reg     <= res.last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = status_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {{(M_TDATA_W - VALUE_W - POSITION_W){1'b0}}, position_reg, value_reg};

endmodule

/* dv/tb_positional_list_engine_unit.sv */
// Self-checking stream testbench for the positional list engine top level.
module tb_positional_list_engine_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import ple_pkg::*;

    // The list capacity is kept at the block's default so that full-list
    // behavior and a display of a full list are reached in a short run.
    localparam int LIST_CAP = 64;
    localparam int HALF_PERIOD = 6;
    localparam int RESET_CYCLES = 9;

    // After the last result, a display of a full list is the longest
    // operation the block can still be busy with, so this quiet wait is
    // enough to catch a stray result.
    localparam int SETTLE_CYCLES = 2 * LIST_CAP + 16;

    // Long receiver hold-off, well beyond the time a full display needs.
    localparam int LONG_HOLD_CYCLES = 300;

    // One predicted result transaction on the master side.
    typedef struct packed {
        status_t                status;
        logic [VALUE_W-1:0]     value;
        logic [POSITION_W-1:0]  position;
        logic                   is_final;
    } list_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic [OPCODE_W-1:0]   s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [STATUS_W-1:0]   m_tuser;
    logic                  m_tlast;

    // Shadow copy of the list, front entry first, and the results that the
    // block still owes us, oldest first.
    logic signed [VALUE_W-1:0] list_model[$];
    list_result_t              pending_results[$];

    int error_count = 0;
    int ops_accepted = 0;
    int results_checked = 0;
    int peak_length = 0;
    int input_stall_cycles = 0;
    int status_count[0:4] = '{default: 0};

    // Random idling on each side can be switched off for the final stretch.
    bit sender_bursts = 1'b1;
    bit receiver_bursts = 1'b1;

    // A nonzero value asks the receiver process to hold m_tready low;
    // the value gives the length of the hold.
    int hold_request = 0;

    // Direction of the random walk over the list length.
    bit list_growing = 1'b1;

    positional_list_engine_unit #(
        .CAPACITY(LIST_CAP)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // Hard stop in case the block hangs. The slowest correct run, with every
    // item a full display and every result waiting out the longest stall, is
    // a few milliseconds; this allows several times that.
    initial
    begin
        #20_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // List predictor
    // ------------------------------------------------------------------

    function automatic void add_outcome(status_t st, logic [VALUE_W-1:0] val,
                                        logic [POSITION_W-1:0] pos, logic fin);
        list_result_t r;
        r.status = st;
        r.value = val;
        r.position = pos;
        r.is_final = fin;
        pending_results.push_back(r);
        status_count[int'(st)]++;
    endfunction

    // Every rejection carries a zero value and position and closes the
    // transaction.
    function automatic void add_rejection(status_t st);
        add_outcome(st, '0, '0, 1'b1);
    endfunction

    // Applies one accepted operation to the shadow list and queues the
    // results the block must return for it.
    function automatic void apply_list_op(opcode_t op, logic [POSITION_W-1:0] pos,
                                          logic [VALUE_W-1:0] val);
        int len;
        int slot;
        logic [VALUE_W-1:0] taken;
        len = list_model.size();
        slot = int'(pos);
        case (op)
            OP_CREATE:
                if (len != 0)
                    add_rejection(ST_EXISTS);
                else
                begin
                    list_model.push_back(val);
                    add_outcome(ST_OK, val, 7'd1, 1'b1);
                end
            OP_INS_FRONT:
                if (len >= LIST_CAP)
                    add_rejection(ST_FULL);
                else
                begin
                    list_model.push_front(val);
                    add_outcome(ST_OK, val, 7'd1, 1'b1);
                end
            OP_INS_END:
                if (len >= LIST_CAP)
                    add_rejection(ST_FULL);
                else
                begin
                    list_model.push_back(val);
                    add_outcome(ST_OK, val, 7'(len + 1), 1'b1);
                end
            OP_INS_AT:
                // The position is judged before fullness.
                if (slot == 0 || slot > len + 1)
                    add_rejection(ST_BADPOS);
                else if (len >= LIST_CAP)
                    add_rejection(ST_FULL);
                else
                begin
                    list_model.insert(slot - 1, val);
                    add_outcome(ST_OK, val, pos, 1'b1);
                end
            OP_DEL_FIRST:
                if (len == 0)
                    add_rejection(ST_EMPTY);
                else
                begin
                    taken = list_model.pop_front();
                    add_outcome(ST_OK, taken, 7'd1, 1'b1);
                end
            OP_DEL_LAST:
                if (len == 0)
                    add_rejection(ST_EMPTY);
                else
                begin
                    taken = list_model.pop_back();
                    add_outcome(ST_OK, taken, 7'(len), 1'b1);
                end
            OP_DEL_AT:
                // An empty list wins over a bad position.
                if (len == 0)
                    add_rejection(ST_EMPTY);
                else if (slot == 0 || slot > len)
                    add_rejection(ST_BADPOS);
                else
                begin
                    taken = list_model[slot - 1];
                    list_model.delete(slot - 1);
                    add_outcome(ST_OK, taken, pos, 1'b1);
                end
            default:
                if (len == 0)
                    add_rejection(ST_EMPTY);
                else
                    for (int k = 0; k < len; k++)
                        add_outcome(ST_OK, list_model[k], 7'(k + 1), k == len - 1);
        endcase
        if (list_model.size() > peak_length)
            peak_length = list_model.size();
    endfunction

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Offers one operation and returns at the edge where it is accepted.
    // s_tvalid is left high so that a following call can present the next
    // transaction back to back; any code that waits instead must lower it.
    task automatic issue_op(opcode_t op, logic [POSITION_W-1:0] pos,
                            logic [VALUE_W-1:0] val);
        int gap;
        if (sender_bursts && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 12);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {1'b0, val, pos};
        do
            @(posedge clk);
        while (!s_tready);
        ops_accepted++;
        apply_list_op(op, pos, val);
    endtask

    // Stops offering and waits until the block has returned every result.
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Mostly a legal position for the positional operations, sometimes any
    // 7-bit value so that out-of-range positions and all position bits occur.
    function automatic logic [POSITION_W-1:0] pick_position(opcode_t op, int len, bit wild);
        int top;
        top = (op == OP_INS_AT) ? len + 1 : len;
        if (wild || top == 0 || $urandom_range(0, 6) == 0)
            return 7'($urandom_range(0, 127));
        return 7'($urandom_range(1, top));
    endfunction

    // ------------------------------------------------------------------
    // Receiver side
    // ------------------------------------------------------------------

    // Drives m_tready: normally high, with random low bursts, and one long
    // hold-off on request so that the block fills its output and stalls.
    initial
    begin : receiver
        int span;
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                span = hold_request;
                hold_request = 0;
                m_tready <= 1'b0;
                for (int c = 0; c < span; c++)
                    @(posedge clk);
                m_tready <= 1'b1;
            end
            else if (receiver_bursts && $urandom_range(0, 9) == 0)
            begin
                span = $urandom_range(1, 12);
                m_tready <= 1'b0;
                repeat (span) @(posedge clk);
                m_tready <= 1'b1;
            end
            else
                m_tready <= 1'b1;
        end
    end

    task automatic report_mismatch(string field, logic [VALUE_W-1:0] want_v,
                                   logic [VALUE_W-1:0] got_v);
        $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want_v, got_v);
        error_count++;
    endtask

    // Compares every accepted result transaction with the oldest prediction.
    // Signals are read in the active region right after the edge, so they
    // still hold the values that the edge sampled.
    always @(posedge clk)
    begin : result_checker
        list_result_t want;
        if (s_tvalid && !s_tready)
            input_stall_cycles++;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result, actual status %0d value %h position %0d last %b",
                         $time, m_tuser, m_tdata[31:0], m_tdata[38:32], m_tlast);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                results_checked++;
                if (m_tuser !== want.status)
                    report_mismatch("status", 32'(want.status), 32'(m_tuser));
                if (m_tdata[31:0] !== want.value)
                    report_mismatch("result_value", want.value, m_tdata[31:0]);
                if (m_tdata[38:32] !== want.position)
                    report_mismatch("result_position", 32'(want.position),
                                    32'(m_tdata[38:32]));
                if (m_tlast !== want.is_final)
                    report_mismatch("last", 32'(want.is_final), 32'(m_tlast));
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Every operation that reads or removes from an empty list, and
    // positional inserts into an empty list at positions other than the only legal one.
    task automatic test_empty_list();
        issue_op(OP_DISPLAY, 7'd0, 32'h0000_0000);
        issue_op(OP_DEL_FIRST, 7'd1, 32'hFFFF_FFFF);
        issue_op(OP_DEL_LAST, 7'd127, 32'h0000_0000);
        issue_op(OP_DEL_AT, 7'd0, 32'h0000_0000);
        issue_op(OP_INS_AT, 7'd0, 32'h5555_5555);
        issue_op(OP_INS_AT, 7'd3, 32'hAAAA_AAAA);
        wait_for_results();
    endtask

    // Walks a short list through each operation, the extreme values and
    // the positions just inside and just outside the legal range.
    task automatic test_directed_ops();
        issue_op(OP_CREATE, 7'd0, 32'h8000_0000);
        issue_op(OP_CREATE, 7'd1, 32'h0000_0001);
        issue_op(OP_INS_FRONT, 7'd0, 32'h7FFF_FFFF);
        issue_op(OP_INS_END, 7'd0, 32'hFFFF_FFFF);
        issue_op(OP_INS_AT, 7'd2, 32'h0000_0001);
        issue_op(OP_INS_AT, 7'd5, 32'h1234_5678);
        issue_op(OP_INS_AT, 7'd7, 32'h0BAD_0BAD);
        issue_op(OP_INS_AT, 7'd127, 32'h0BAD_0BAD);
        issue_op(OP_DEL_AT, 7'd0, 32'h0000_0000);
        issue_op(OP_DEL_AT, 7'd6, 32'h0000_0000);
        issue_op(OP_DISPLAY, 7'd0, 32'h0000_0000);
        issue_op(OP_DEL_AT, 7'd3, 32'h0000_0000);
        issue_op(OP_DEL_FIRST, 7'd0, 32'h0000_0000);
        issue_op(OP_DEL_LAST, 7'd0, 32'h0000_0000);
        issue_op(OP_DISPLAY, 7'd0, 32'h0000_0000);
        issue_op(OP_DEL_AT, 7'd2, 32'h0000_0000);
        issue_op(OP_DEL_LAST, 7'd0, 32'h0000_0000);
        // Insert at position 1 is the one legal positional insert into an
        // empty list.
        issue_op(OP_INS_AT, 7'd1, 32'hDEAD_BEEF);
        issue_op(OP_DEL_AT, 7'd1, 32'h0000_0000);
        wait_for_results();
    endtask

    // Fills the list to capacity with mixed inserts, then checks that
    // every insert is refused, that a bad position beats fullness, and
    // that a display returns the whole list.
    task automatic test_full_list();
        int len;
        while (list_model.size() < LIST_CAP)
        begin
            len = list_model.size();
            case ($urandom_range(0, 2))
                0: issue_op(OP_INS_FRONT, 7'($urandom_range(0, 127)), $urandom());
                1: issue_op(OP_INS_END, 7'($urandom_range(0, 127)), $urandom());
                default: issue_op(OP_INS_AT, 7'($urandom_range(1, len + 1)), $urandom());
            endcase
        end
        issue_op(OP_INS_FRONT, 7'd0, $urandom());
        issue_op(OP_INS_END, 7'd0, $urandom());
        issue_op(OP_INS_AT, 7'(LIST_CAP + 1), $urandom());
        issue_op(OP_INS_AT, 7'(LIST_CAP + 2), $urandom());
        issue_op(OP_CREATE, 7'd0, $urandom());
        issue_op(OP_DISPLAY, 7'd0, 32'h0000_0000);
        wait_for_results();
    endtask

    // The receiver holds off for a long stretch while the sender keeps
    // offering a full display and more operations behind it, so the block
    // has to stall its input. Afterwards the sender waits for every result.
    task automatic test_output_stall();
        int len;
        hold_request = LONG_HOLD_CYCLES;
        issue_op(OP_DISPLAY, 7'd0, 32'h0000_0000);
        for (int n = 0; n < 8; n++)
        begin
            len = list_model.size();
            if (n % 2 == 0)
                issue_op(OP_DEL_AT, pick_position(OP_DEL_AT, len, 1'b0), $urandom());
            else
                issue_op(OP_INS_AT, pick_position(OP_INS_AT, len, 1'b0), $urandom());
        end
        wait_for_results();
    endtask

    // Random walk over the list length: mostly runs of inserts or runs of
    // deletes with random content, so that the list swings between empty
    // and full, plus displays, creates and fully random operations.
    task automatic test_random_traffic(int count);
        int r;
        int len;
        bit wild;
        opcode_t op;
        for (int n = 0; n < count; n++)
        begin
            len = list_model.size();
            // Turn around at the ends only some of the time, so that
            // inserts into a full list and deletes from an empty one occur.
            if (len >= LIST_CAP && $urandom_range(0, 2) == 0)
                list_growing = 1'b0;
            else if (len == 0 && $urandom_range(0, 2) == 0)
                list_growing = 1'b1;
            else if ($urandom_range(0, 59) == 0)
                list_growing = !list_growing;
            r = $urandom_range(0, 99);
            wild = 1'b0;
            if (r < 4)
                op = OP_DISPLAY;
            else if (r < 8)
                op = OP_CREATE;
            else if (r < 16)
            begin
                op = opcode_t'($urandom_range(0, 7));
                wild = 1'b1;
            end
            else if (list_growing)
            begin
                case ($urandom_range(0, 2))
                    0: op = OP_INS_FRONT;
                    1: op = OP_INS_END;
                    default: op = OP_INS_AT;
                endcase
            end
            else
            begin
                case ($urandom_range(0, 2))
                    0: op = OP_DEL_FIRST;
                    1: op = OP_DEL_LAST;
                    default: op = OP_DEL_AT;
                endcase
            end
            issue_op(op, pick_position(op, len, wild), $urandom());
        end
        wait_for_results();
    endtask

    // ------------------------------------------------------------------
    // Sequence of the run
    // ------------------------------------------------------------------

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_list();
        test_directed_ops();
        test_full_list();
        test_output_stall();
        test_random_traffic(240);

        // The last stretch runs with both sides always ready.
        sender_bursts = 1'b0;
        receiver_bursts = 1'b0;
        test_random_traffic(60);

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d list operations, %0d checked results, peak length %0d of %0d.",
                 ops_accepted, results_checked, peak_length, LIST_CAP);
        $display("Refusals: %0d exists, %0d empty, %0d bad position, %0d full; %0d input stalls.",
                 status_count[int'(ST_EXISTS)], status_count[int'(ST_EMPTY)],
                 status_count[int'(ST_BADPOS)], status_count[int'(ST_FULL)],
                 input_stall_cycles);
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
